### hw/rtl/bps_pkg.sv
package bps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int BACKLOG_MAX = 15;

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int BL_W      = $clog2(BACKLOG_MAX + 1);

  localparam int CMD_W     = 2;
  localparam int ID_W      = 16;
  localparam int TIME_W    = 48;
  localparam int CTR_W     = 32;
  localparam int SUM_W     = 63;
  localparam int BUDGET_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b1;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd5000000;

  // Commands from the sequencer to the datapath, at most one active per cycle.
  typedef struct packed {
    logic latch;
    logic enqueue;
    logic hold_release;
    logic open_win;
    logic replay;
    logic calc;
    logic acct;
    logic dispatch;
    logic close_win;
    logic publish;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_window;
    logic             enable;
    logic             job_running;
    logic             backlog_nz;
    logic             may_dispatch;
  } status_t;

endpackage

### hw/rtl/bps_ctrl.sv
module bps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bps_pkg::status_t status,
  output bps_pkg::ctrl_t   ctrl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_ACCT   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_CLOSE  = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0] state, state_next;
  logic       replayed, replayed_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctrl           = '0;
    state_next     = state;
    replayed_next  = replayed;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.latch    = 1'b1;
          replayed_next = 1'b0;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_CHECK;
        case (status.cmd)
          bps_pkg::CMD_ENQUEUE: begin
            ctrl.enqueue = 1'b1;
          end
          bps_pkg::CMD_RELEASE: begin
            if (status.in_window) begin
              ctrl.hold_release = 1'b1;
            end else if (status.enable) begin
              ctrl.open_win = 1'b1;
              state_next    = S_DECIDE;
            end
          end
          bps_pkg::CMD_DONE: begin
            if (status.job_running) begin
              ctrl.calc  = 1'b1;
              state_next = S_ACCT;
            end
          end
          default: ;
        endcase
      end
      S_ACCT: begin
        ctrl.acct  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = status.may_dispatch ? S_DISP : S_CLOSE;
      end
      S_DISP: begin
        ctrl.dispatch = 1'b1;
        state_next    = S_CHECK;
      end
      S_CLOSE: begin
        ctrl.close_win = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        // replay at most one held release per beat
        if (!replayed && !status.in_window && status.enable && status.backlog_nz) begin
          ctrl.replay   = 1'b1;
          replayed_next = 1'b1;
          state_next    = S_DECIDE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          ctrl.publish   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      replayed  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      replayed  <= replayed_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/bps_dpath.sv
module bps_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  bps_pkg::ctrl_t                 ctrl,
  output bps_pkg::status_t               status,
  input  logic [bps_pkg::CMD_W-1:0]      command,
  input  logic [bps_pkg::ID_W-1:0]       job_id,
  input  logic [bps_pkg::TIME_W-1:0]     now_time,
  input  logic                           cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_W-1:0]      cfg_data,
  output logic                           dispatch_valid,
  output logic [bps_pkg::ID_W-1:0]       dispatch_job,
  output logic                           window_closed,
  output logic [bps_pkg::CTR_W-1:0]      count_enqueued,
  output logic [bps_pkg::CTR_W-1:0]      count_executed,
  output logic [bps_pkg::CTR_W-1:0]      count_dropped,
  output logic [bps_pkg::CTR_W-1:0]      count_periods,
  output logic [bps_pkg::CTR_W-1:0]      count_idle_periods,
  output logic [bps_pkg::SUM_W-1:0]      sum_response,
  output logic [bps_pkg::TIME_W-1:0]     peak_response,
  output logic [bps_pkg::SUM_W-1:0]      sum_budget_used,
  output logic [bps_pkg::TIME_W-1:0]     peak_budget_used
);

  localparam int TW = bps_pkg::TIME_W;
  localparam int SW = bps_pkg::SUM_W;
  localparam int CW = bps_pkg::CTR_W;
  localparam int PW = bps_pkg::PTR_W;
  localparam int NW = bps_pkg::CNT_W;
  localparam int BW = bps_pkg::BL_W;

  // latched item
  logic [bps_pkg::CMD_W-1:0] cmd_q;
  logic [bps_pkg::ID_W-1:0]  id_q;
  logic [TW-1:0]             now_q;

  logic [bps_pkg::BUDGET_W-1:0] budget;
  logic                         enable;

  // job queue
  logic [bps_pkg::ID_W-1:0] mem_id  [bps_pkg::QUEUE_DEPTH];
  logic [TW-1:0]            mem_arr [bps_pkg::QUEUE_DEPTH];
  logic [bps_pkg::ID_W-1:0] rd_id;
  logic [TW-1:0]            rd_arr;
  logic [PW-1:0]            head, tail;
  logic [NW-1:0]            count;
  logic                     full;

  logic          in_window, running, served_any;
  logic [TW-1:0] start, arrival, consumed;
  logic [BW-1:0] backlog;
  logic [TW-1:0] dt_q, resp_q;

  logic [CW-1:0] cnt_enq, cnt_exec, cnt_drop, cnt_per, cnt_idle;
  logic [SW-1:0] sum_resp, sum_used;
  logic [TW-1:0] peak_resp, peak_used;

  logic                     flag_disp, flag_closed;
  logic [bps_pkg::ID_W-1:0] flag_job;

  logic [SW:0]   sum_resp_add, sum_used_add;
  logic [TW:0]   consumed_add;
  logic [SW-1:0] sum_resp_next, sum_used_next;
  logic [TW-1:0] consumed_next;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (&v) ? v : v + CW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(bps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full = (count >= NW'(bps_pkg::QUEUE_DEPTH));

  always_comb begin
    sum_resp_add  = {1'b0, sum_resp} + (SW + 1)'(resp_q);
    sum_used_add  = {1'b0, sum_used} + (SW + 1)'(consumed);
    consumed_add  = {1'b0, consumed} + {1'b0, dt_q};
    sum_resp_next = sum_resp_add[SW] ? {SW{1'b1}} : sum_resp_add[SW-1:0];
    sum_used_next = sum_used_add[SW] ? {SW{1'b1}} : sum_used_add[SW-1:0];
    consumed_next = consumed_add[TW] ? {TW{1'b1}} : consumed_add[TW-1:0];
  end

  always_comb begin
    status.cmd          = cmd_q;
    status.in_window    = in_window;
    status.enable       = enable;
    status.job_running  = running;
    status.backlog_nz   = (backlog != '0);
    status.may_dispatch = enable && (count != '0) && (consumed < TW'(budget));
  end

  // queue storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctrl.enqueue && !full) begin
      mem_id[tail]  <= id_q;
      mem_arr[tail] <= now_q;
    end
    rd_id  <= mem_id[head];
    rd_arr <= mem_arr[head];
  end

  // item latch, time differences, and the published result beat
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q <= command;
      id_q  <= job_id;
      now_q <= now_time;
    end
    if (ctrl.calc) begin
      dt_q   <= now_q - start;
      resp_q <= now_q - arrival;
    end
    if (ctrl.publish) begin
      dispatch_valid     <= flag_disp;
      dispatch_job       <= flag_job;
      window_closed      <= flag_closed;
      count_enqueued     <= cnt_enq;
      count_executed     <= cnt_exec;
      count_dropped      <= cnt_drop;
      count_periods      <= cnt_per;
      count_idle_periods <= cnt_idle;
      sum_response       <= sum_resp;
      peak_response      <= peak_resp;
      sum_budget_used    <= sum_used;
      peak_budget_used   <= peak_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget      <= bps_pkg::BUDGET_RESET;
      enable      <= 1'b1;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      in_window   <= 1'b0;
      running     <= 1'b0;
      served_any  <= 1'b0;
      start       <= '0;
      arrival     <= '0;
      consumed    <= '0;
      backlog     <= '0;
      cnt_enq     <= '0;
      cnt_exec    <= '0;
      cnt_drop    <= '0;
      cnt_per     <= '0;
      cnt_idle    <= '0;
      sum_resp    <= '0;
      sum_used    <= '0;
      peak_resp   <= '0;
      peak_used   <= '0;
      flag_disp   <= 1'b0;
      flag_job    <= '0;
      flag_closed <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bps_pkg::REG_BUDGET: budget <= cfg_data[bps_pkg::BUDGET_W-1:0];
          bps_pkg::REG_ENABLE: enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctrl.latch) begin
        flag_disp   <= 1'b0;
        flag_job    <= '0;
        flag_closed <= 1'b0;
      end
      if (ctrl.enqueue) begin
        if (!full) begin
          tail    <= ptr_inc(tail);
          count   <= count + NW'(1);
          cnt_enq <= sat_inc(cnt_enq);
        end else begin
          cnt_drop <= sat_inc(cnt_drop);
        end
      end
      if (ctrl.hold_release && (backlog < BW'(bps_pkg::BACKLOG_MAX))) begin
        backlog <= backlog + BW'(1);
      end
      if (ctrl.open_win || ctrl.replay) begin
        in_window  <= 1'b1;
        consumed   <= '0;
        served_any <= 1'b0;
      end
      if (ctrl.replay) begin
        backlog <= backlog - BW'(1);
      end
      if (ctrl.acct) begin
        running  <= 1'b0;
        cnt_exec <= sat_inc(cnt_exec);
        sum_resp <= sum_resp_next;
        consumed <= consumed_next;
        if (resp_q > peak_resp) begin
          peak_resp <= resp_q;
        end
      end
      if (ctrl.dispatch) begin
        flag_disp  <= 1'b1;
        flag_job   <= rd_id;
        arrival    <= rd_arr;
        start      <= now_q;
        head       <= ptr_inc(head);
        count      <= count - NW'(1);
        running    <= 1'b1;
        served_any <= 1'b1;
      end
      if (ctrl.close_win) begin
        cnt_per  <= sat_inc(cnt_per);
        sum_used <= sum_used_next;
        if (!served_any) begin
          cnt_idle <= sat_inc(cnt_idle);
        end
        if (consumed > peak_used) begin
          peak_used <= consumed;
        end
        in_window   <= 1'b0;
        flag_closed <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/budgeted_polling_server_core.sv
// Budgeted polling server: each input beat is a timestamped event (enqueue a job, period
// release, or completion of the running job) and yields exactly one result beat carrying
// the dispatch decision, a window-closed flag and a snapshot of all statistics. Jobs wait
// in a 16-entry FIFO with their arrival times; an enabled release opens a service window that
// dispatches head jobs while the consumed time stays below the budget register, and a
// release seen during a window is held in a saturating backlog and replayed once per beat
// afterwards. One beat is handled at a time by a small sequencer. After the accepting
// edge, an enqueue, an ignored event or a held release passes the execute, check and
// output states; a release that opens a window also passes decide and then dispatch or
// close; a completion computes the time differences, accumulates, then decides; and
// replaying a held release adds another decide and dispatch or close. Dispatch uses the
// registered FIFO head read, and the accumulates saturate. The next beat is accepted as
// soon as the sequencer is back in its idle state, even while the previous result still
// waits under out_stall. Config writes (index 0 budget, index 1 server_enable) are always
// ready and are meant to happen only while the block is idle.
module budgeted_polling_server_core (
  input  logic                           clk,
  input  logic                           rst,
  // event channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bps_pkg::CMD_W-1:0]      command,
  input  logic [bps_pkg::ID_W-1:0]       job_id,
  input  logic [bps_pkg::TIME_W-1:0]     now_time,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           dispatch_valid,
  output logic [bps_pkg::ID_W-1:0]       dispatch_job,
  output logic                           window_closed,
  output logic [bps_pkg::CTR_W-1:0]      count_enqueued,
  output logic [bps_pkg::CTR_W-1:0]      count_executed,
  output logic [bps_pkg::CTR_W-1:0]      count_dropped,
  output logic [bps_pkg::CTR_W-1:0]      count_periods,
  output logic [bps_pkg::CTR_W-1:0]      count_idle_periods,
  output logic [bps_pkg::SUM_W-1:0]      sum_response,
  output logic [bps_pkg::TIME_W-1:0]     peak_response,
  output logic [bps_pkg::SUM_W-1:0]      sum_budget_used,
  output logic [bps_pkg::TIME_W-1:0]     peak_budget_used,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_W-1:0]      cfg_data
);

  bps_pkg::ctrl_t   ctrl;
  bps_pkg::status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: walks each beat through command, accounting, dispatch/close and replay
  bps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  // datapath: queue, window state, statistics and the result register
  bps_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .status             (status),
    .command            (command),
    .job_id             (job_id),
    .now_time           (now_time),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .dispatch_valid     (dispatch_valid),
    .dispatch_job       (dispatch_job),
    .window_closed      (window_closed),
    .count_enqueued     (count_enqueued),
    .count_executed     (count_executed),
    .count_dropped      (count_dropped),
    .count_periods      (count_periods),
    .count_idle_periods (count_idle_periods),
    .sum_response       (sum_response),
    .peak_response      (peak_response),
    .sum_budget_used    (sum_budget_used),
    .peak_budget_used   (peak_budget_used)
  );

endmodule
